// File: rtl/assert_macros.svh
// concurrent assertion helpers for the grid search block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// plain property, checked outside reset
`define SGNS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// overlapping implication, checked outside reset
`define SGNS_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`else
`define SGNS_ASSERT(lbl, clk, rst_n, prop, msg)
`define SGNS_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

// File: rtl/sgns_pkg.sv
`default_nettype none
package sgns_pkg;

    localparam int MAX_POINTS  = 64;
    localparam int MAX_CELLS_X = 64;
    localparam int MAX_CELLS_Y = 64;

    localparam int PT_W     = $clog2(MAX_POINTS);
    localparam int CNT_W    = PT_W + 1;
    localparam int CELL_CAP = MAX_CELLS_X * MAX_CELLS_Y;
    localparam int CELL_W   = $clog2(CELL_CAP);
    localparam int CO_W     = ($clog2(MAX_CELLS_X) > $clog2(MAX_CELLS_Y)) ?
                              $clog2(MAX_CELLS_X) : $clog2(MAX_CELLS_Y);

    localparam int DIM_W  = 7;
    localparam int INV_W  = 16;
    localparam int POS_W  = 16;
    localparam int TAG_W  = 16;
    localparam int ID_W   = 6;
    localparam int FRAC_W = 16;
    localparam int PROD_W = POS_W + INV_W + 1;
    localparam int GRID_W = PROD_W - FRAC_W;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [1:0] REG_CELLS_X = 2'd0;
    localparam logic [1:0] REG_CELLS_Y = 2'd1;
    localparam logic [1:0] REG_INV     = 2'd2;

    localparam logic [DIM_W-1:0] CELLS_X_RST = 7'd16;
    localparam logic [DIM_W-1:0] CELLS_Y_RST = 7'd16;
    localparam logic [INV_W-1:0] INV_RST     = 16'd256;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic [DIM_W-1:0] nx;
        logic [DIM_W-1:0] ny;
        logic [INV_W-1:0] inv;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic query;
        logic idx_zero;
        logic idx_inc;
        logic clr_wr;
        logic pos_rd;
        logic mul_x;
        logic mul_y;
        logic mul_q;
        logic cap_gy;
        logic bin_cmul;
        logic bin_cell;
        logic bin_wr;
        logic cnt_inc;
        logic walk_init;
        logic cnt_rd;
        logic walk_wr;
        logic bin_rd;
        logic end_rd_p;
        logic place_wr;
        logic q_lim;
        logic q_cmul;
        logic q_cell;
        logic q_end_rd;
        logic q_bnd;
        logic q_step;
        logic q_next;
        logic q_id;
        logic q_fin;
    } t_cmd;

    typedef struct packed {
        logic pt_last;
        logic cell_last;
        logic clr_last;
        logic q_empty;
        logic j_more;
        logic y_more;
        logic x_more;
    } t_sts;

endpackage
`default_nettype wire

// File: rtl/spatial_grid_neighbor_search.sv
// Uniform-grid neighbor search over up to 64 points in Q8.8. A transaction is
// taken when start is high and busy is low; the receiver cannot stall, so each
// result appears on the o_ ports for exactly one cycle with o_valid high, and
// o_last marks the final one of a query. A load without last_point leaves busy
// low. The closing load runs the grid build: binning of each point (one shared
// 16x17 multiplier, read-modify-write of the count memory), the running-sum walk
// over the grid cells, and placing of the ids. A query scales its position,
// limits its neighborhood, then reads the bounds of each visited cell from the
// cell-bound memory and steps through the ids found there, and then finishes; a
// query whose neighborhood lies wholly outside the grid skips the cell walk
// after that check. After reset the block is busy while it clears the count
// memory; register writes are taken during that time.
`default_nettype none
`include "assert_macros.svh"
module spatial_grid_neighbor_search (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_opcode,
    input  logic signed [sgns_pkg::POS_W-1:0]  i_pos_x,
    input  logic signed [sgns_pkg::POS_W-1:0]  i_pos_y,
    input  logic                               i_last_point,
    input  logic [sgns_pkg::TAG_W-1:0]         i_query_id,
    output logic                               o_valid,
    output logic [sgns_pkg::TAG_W-1:0]         o_tag_out,
    output logic [sgns_pkg::ID_W-1:0]          o_neighbor_id,
    output logic                               o_found,
    output logic                               o_last,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sgns_pkg::ADDR_W-1:0]        paddr,
    input  logic [sgns_pkg::DATA_W-1:0]        pwdata,
    output logic [sgns_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);
    import sgns_pkg::*;

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;

    // register file, grid size already clamped into range
    sgns_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // sequencer for loads, the build phases and the query walk
    sgns_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_opcode     (i_opcode),
        .i_last_point (i_last_point),
        .i_sts        (sts),
        .o_cmd        (cmd),
        .o_busy       (busy)
    );

    // point store, count and bound memories, multiplier, result register
    sgns_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_cmd         (cmd),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_last_point  (i_last_point),
        .i_query_id    (i_query_id),
        .o_sts         (sts),
        .o_valid       (o_valid),
        .o_tag_out     (o_tag_out),
        .o_neighbor_id (o_neighbor_id),
        .o_found       (o_found),
        .o_last        (o_last)
    );

    // results only come out of a running query
    `SGNS_ASSERT_IMPL(a_res_in_query, i_clk, i_rst_n, o_valid, $past(busy), "result outside query")
    // an empty answer is a single closing result with id zero
    `SGNS_ASSERT_IMPL(a_empty_form, i_clk, i_rst_n, o_valid && !o_found, o_last && (o_neighbor_id == '0), "bad empty result")
    // a plain load finishes in its own cycle
    `SGNS_ASSERT(a_load_quick, i_clk, i_rst_n, (start && !busy && !i_opcode && !i_last_point) |=> !busy, "load held block busy")
    // a query always occupies the block
    `SGNS_ASSERT(a_query_busy, i_clk, i_rst_n, (start && !busy && i_opcode) |=> busy, "query did not start")

endmodule
`default_nettype wire

// File: rtl/sgns_regs.sv
`default_nettype none
module sgns_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sgns_pkg::ADDR_W-1:0]  paddr,
    input  logic [sgns_pkg::DATA_W-1:0]  pwdata,
    output logic [sgns_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output sgns_pkg::t_cfg               o_cfg
);
    import sgns_pkg::*;

    logic [DIM_W-1:0] r_cells_x;
    logic [DIM_W-1:0] r_cells_y;
    logic [INV_W-1:0] r_inv;
    logic             wr;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d,
                                                 input int mx);
        if (d == '0) begin
            eff_dim = DIM_W'(1);
        end else if (int'(d) > mx) begin
            eff_dim = DIM_W'(mx);
        end else begin
            eff_dim = d;
        end
    endfunction

    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells_x <= CELLS_X_RST;
            r_cells_y <= CELLS_Y_RST;
            r_inv     <= INV_RST;
        end else if (wr) begin
            unique case (paddr[3:2])
                REG_CELLS_X: r_cells_x <= pwdata[DIM_W-1:0];
                REG_CELLS_Y: r_cells_y <= pwdata[DIM_W-1:0];
                REG_INV:     r_inv     <= pwdata[INV_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_CELLS_X: prdata = DATA_W'(r_cells_x);
            REG_CELLS_Y: prdata = DATA_W'(r_cells_y);
            REG_INV:     prdata = DATA_W'(r_inv);
            default:     prdata = '0;
        endcase
    end

    assign o_cfg.nx  = eff_dim(r_cells_x, MAX_CELLS_X);
    assign o_cfg.ny  = eff_dim(r_cells_y, MAX_CELLS_Y);
    assign o_cfg.inv = r_inv;

endmodule
`default_nettype wire

// File: rtl/sgns_ctrl.sv
`default_nettype none
module sgns_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_opcode,
    input  logic           i_last_point,
    input  sgns_pkg::t_sts i_sts,
    output sgns_pkg::t_cmd o_cmd,
    output logic           o_busy
);
    import sgns_pkg::*;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_CLR  = 5'd1;
    localparam logic [4:0] S_BRD  = 5'd2;
    localparam logic [4:0] S_BMX  = 5'd3;
    localparam logic [4:0] S_BMY  = 5'd4;
    localparam logic [4:0] S_BMC  = 5'd5;
    localparam logic [4:0] S_BCL  = 5'd6;
    localparam logic [4:0] S_BCR  = 5'd7;
    localparam logic [4:0] S_BCW  = 5'd8;
    localparam logic [4:0] S_WSET = 5'd9;
    localparam logic [4:0] S_WRD  = 5'd10;
    localparam logic [4:0] S_WWR  = 5'd11;
    localparam logic [4:0] S_PSET = 5'd12;
    localparam logic [4:0] S_PRD  = 5'd13;
    localparam logic [4:0] S_PER  = 5'd14;
    localparam logic [4:0] S_PWR  = 5'd15;
    localparam logic [4:0] S_QMX  = 5'd16;
    localparam logic [4:0] S_QMY  = 5'd17;
    localparam logic [4:0] S_QRG  = 5'd18;
    localparam logic [4:0] S_QLIM = 5'd19;
    localparam logic [4:0] S_QCM  = 5'd20;
    localparam logic [4:0] S_QCA  = 5'd21;
    localparam logic [4:0] S_QER  = 5'd22;
    localparam logic [4:0] S_QEB  = 5'd23;
    localparam logic [4:0] S_QJ   = 5'd24;
    localparam logic [4:0] S_QID  = 5'd25;
    localparam logic [4:0] S_QFIN = 5'd26;

    logic [4:0] r_state;
    logic [4:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_opcode == OP_LOAD) begin
                        o_cmd.load = 1'b1;
                        if (i_last_point) begin
                            o_cmd.idx_zero = 1'b1;
                            n_state        = S_BRD;
                        end
                    end else begin
                        o_cmd.query = 1'b1;
                        n_state     = S_QMX;
                    end
                end
            end
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    o_cmd.idx_zero = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_BRD: begin
                o_cmd.pos_rd = 1'b1;
                n_state      = S_BMX;
            end
            S_BMX: begin
                o_cmd.mul_x = 1'b1;
                n_state     = S_BMY;
            end
            S_BMY: begin
                o_cmd.mul_y = 1'b1;
                n_state     = S_BMC;
            end
            S_BMC: begin
                o_cmd.cap_gy   = 1'b1;
                o_cmd.bin_cmul = 1'b1;
                n_state        = S_BCL;
            end
            S_BCL: begin
                o_cmd.bin_cell = 1'b1;
                n_state        = S_BCR;
            end
            S_BCR: begin
                o_cmd.bin_wr = 1'b1;
                n_state      = S_BCW;
            end
            S_BCW: begin
                o_cmd.cnt_inc = 1'b1;
                if (i_sts.pt_last) begin
                    n_state = S_WSET;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_BRD;
                end
            end
            S_WSET: begin
                o_cmd.walk_init = 1'b1;
                o_cmd.idx_zero  = 1'b1;
                n_state         = S_WRD;
            end
            S_WRD: begin
                o_cmd.cnt_rd = 1'b1;
                n_state      = S_WWR;
            end
            S_WWR: begin
                o_cmd.walk_wr = 1'b1;
                if (i_sts.cell_last) begin
                    n_state = S_PSET;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_WRD;
                end
            end
            S_PSET: begin
                o_cmd.idx_zero = 1'b1;
                n_state        = S_PRD;
            end
            S_PRD: begin
                o_cmd.bin_rd = 1'b1;
                n_state      = S_PER;
            end
            S_PER: begin
                o_cmd.end_rd_p = 1'b1;
                n_state        = S_PWR;
            end
            S_PWR: begin
                o_cmd.place_wr = 1'b1;
                if (i_sts.pt_last) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_PRD;
                end
            end
            S_QMX: begin
                o_cmd.mul_x = 1'b1;
                o_cmd.mul_q = 1'b1;
                n_state     = S_QMY;
            end
            S_QMY: begin
                o_cmd.mul_y = 1'b1;
                o_cmd.mul_q = 1'b1;
                n_state     = S_QRG;
            end
            S_QRG: begin
                o_cmd.cap_gy = 1'b1;
                n_state      = S_QLIM;
            end
            S_QLIM: begin
                o_cmd.q_lim = 1'b1;
                n_state     = S_QCM;
            end
            S_QCM: begin
                if (i_sts.q_empty) begin
                    n_state = S_QFIN;
                end else begin
                    o_cmd.q_cmul = 1'b1;
                    n_state      = S_QCA;
                end
            end
            S_QCA: begin
                o_cmd.q_cell = 1'b1;
                n_state      = S_QER;
            end
            S_QER: begin
                o_cmd.q_end_rd = 1'b1;
                n_state        = S_QEB;
            end
            S_QEB: begin
                o_cmd.q_bnd = 1'b1;
                n_state     = S_QJ;
            end
            S_QJ: begin
                priority if (i_sts.j_more) begin
                    o_cmd.q_step = 1'b1;
                    n_state      = S_QID;
                end else if (i_sts.y_more || i_sts.x_more) begin
                    o_cmd.q_next = 1'b1;
                    n_state      = S_QCM;
                end else begin
                    n_state = S_QFIN;
                end
            end
            S_QID: begin
                o_cmd.q_id = 1'b1;
                n_state    = S_QJ;
            end
            S_QFIN: begin
                o_cmd.q_fin = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/sgns_dp.sv
`default_nettype none
module sgns_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  sgns_pkg::t_cfg                     i_cfg,
    input  sgns_pkg::t_cmd                     i_cmd,
    input  logic signed [sgns_pkg::POS_W-1:0]  i_pos_x,
    input  logic signed [sgns_pkg::POS_W-1:0]  i_pos_y,
    input  logic                               i_last_point,
    input  logic [sgns_pkg::TAG_W-1:0]         i_query_id,
    output sgns_pkg::t_sts                     o_sts,
    output logic                               o_valid,
    output logic [sgns_pkg::TAG_W-1:0]         o_tag_out,
    output logic [sgns_pkg::ID_W-1:0]          o_neighbor_id,
    output logic                               o_found,
    output logic                               o_last
);
    import sgns_pkg::*;

    // storage
    logic [2*POS_W-1:0] pos_mem [MAX_POINTS];
    logic [CELL_W-1:0]  bin_mem [MAX_POINTS];
    logic [CNT_W-1:0]   cnt_mem [CELL_CAP];
    logic [CNT_W-1:0]   end_mem [CELL_CAP];
    logic [PT_W-1:0]    sid_mem [MAX_POINTS];

    logic [CNT_W-1:0]         r_total;
    logic                     r_set_open;
    logic [CELL_W-1:0]        r_idx;
    logic [CNT_W-1:0]         r_run;
    logic [CELL_W:0]          r_ncells;
    logic [CNT_W-1:0]         r_nb;
    logic [2*POS_W-1:0]       r_pos_rd;
    logic [CELL_W-1:0]        r_bin_rd;
    logic [CNT_W-1:0]         r_cnt_rd;
    logic [CNT_W-1:0]         r_end_ma;
    logic [CNT_W-1:0]         r_end_mb;
    logic                     r_a_hi;
    logic                     r_b_hi;
    logic [PT_W-1:0]          r_sid_rd;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [GRID_W-1:0] r_gx;
    logic signed [GRID_W-1:0] r_gy;
    logic [CELL_W-1:0]        r_cmul;
    logic [CELL_W-1:0]        r_cell;
    logic signed [POS_W-1:0]  r_qx;
    logic signed [POS_W-1:0]  r_qy;
    logic [TAG_W-1:0]         r_tag;
    logic [CO_W-1:0]          r_x1;
    logic [CO_W-1:0]          r_y0;
    logic [CO_W-1:0]          r_y1;
    logic [CO_W-1:0]          r_x;
    logic [CO_W-1:0]          r_y;
    logic                     r_empty;
    logic [CNT_W-1:0]         r_j;
    logic [CNT_W-1:0]         r_jend;
    logic [CNT_W-1:0]         r_count;
    logic                     r_pend_v;
    logic [PT_W-1:0]          r_pend_id;

    logic                      wr_ok;
    logic [PT_W-1:0]           wr_addr;
    logic signed [POS_W-1:0]   mul_a;
    logic signed [PROD_W-1:0]  prod_n;
    logic [CO_W-1:0]           cmul_x;
    logic [CO_W+DIM_W-1:0]     cmul_n;
    logic [2*DIM_W-1:0]        ncells_n;
    logic [CELL_W:0]           idx_p1;
    logic [CELL_W-1:0]         ra_a;
    logic [CELL_W:0]           ra_b;
    logic [CNT_W-1:0]          end_a;
    logic [CNT_W-1:0]          end_b;
    logic [CNT_W-1:0]          end_dec;
    logic [CNT_W-1:0]          run_n;
    logic                      lim_ex;
    logic                      lim_ey;
    logic [CO_W-1:0]           lo_x;
    logic [CO_W-1:0]           hi_x;
    logic [CO_W-1:0]           lo_y;
    logic [CO_W-1:0]           hi_y;

    function automatic logic [CO_W-1:0] clamp_coord(input logic signed [GRID_W-1:0] g,
                                                    input logic [DIM_W-1:0] n);
        logic [DIM_W-1:0]         nm1;
        logic signed [GRID_W-1:0] top;
        nm1 = n - DIM_W'(1);
        top = $signed({{(GRID_W-DIM_W){1'b0}}, nm1});
        if (g < 0) begin
            clamp_coord = '0;
        end else if (g > top) begin
            clamp_coord = nm1[CO_W-1:0];
        end else begin
            clamp_coord = g[CO_W-1:0];
        end
    endfunction

    // neighborhood span around the centre, empty if wholly outside the grid
    function automatic logic [2*CO_W:0] span(input logic signed [GRID_W-1:0] g,
                                             input logic [DIM_W-1:0] n);
        logic [DIM_W-1:0]         nm1;
        logic signed [GRID_W-1:0] sn;
        logic signed [GRID_W-1:0] snm1;
        logic signed [GRID_W-1:0] gm1;
        logic signed [GRID_W-1:0] gp1;
        logic                     e;
        logic [CO_W-1:0]          lo;
        logic [CO_W-1:0]          hi;
        nm1  = n - DIM_W'(1);
        sn   = $signed({{(GRID_W-DIM_W){1'b0}}, n});
        snm1 = $signed({{(GRID_W-DIM_W){1'b0}}, nm1});
        gm1  = g - GRID_W'(1);
        gp1  = g + GRID_W'(1);
        e    = (g < -1) || (g > sn);
        lo   = (g < 1) ? '0 : gm1[CO_W-1:0];
        hi   = (g >= snm1) ? nm1[CO_W-1:0] : gp1[CO_W-1:0];
        span = {e, lo, hi};
    endfunction

    assign wr_ok   = !r_set_open || (r_total < CNT_W'(MAX_POINTS));
    assign wr_addr = r_set_open ? r_total[PT_W-1:0] : '0;

    always_comb begin
        if (i_cmd.mul_q) begin
            mul_a = i_cmd.mul_x ? r_qx : r_qy;
        end else begin
            mul_a = i_cmd.mul_x ? $signed(r_pos_rd[2*POS_W-1:POS_W])
                                : $signed(r_pos_rd[POS_W-1:0]);
        end
        prod_n = mul_a * $signed({1'b0, i_cfg.inv});
    end

    assign cmul_x   = i_cmd.bin_cmul ? clamp_coord(r_gx, i_cfg.nx) : r_x;
    assign cmul_n   = cmul_x * i_cfg.ny;
    assign ncells_n = i_cfg.nx * i_cfg.ny;
    assign idx_p1   = {1'b0, r_idx} + (CELL_W+1)'(1);

    assign ra_a    = i_cmd.q_end_rd ? r_cell : r_bin_rd;
    assign ra_b    = {1'b0, r_cell} + (CELL_W+1)'(1);
    assign end_a   = r_a_hi ? r_nb : r_end_ma;
    assign end_b   = r_b_hi ? r_nb : r_end_mb;
    assign end_dec = end_a - CNT_W'(1);
    assign run_n   = r_run + r_cnt_rd;

    assign {lim_ex, lo_x, hi_x} = span(r_gx, i_cfg.nx);
    assign {lim_ey, lo_y, hi_y} = span(r_gy, i_cfg.ny);

    // point and id stores
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && wr_ok) begin
            pos_mem[wr_addr] <= {i_pos_x, i_pos_y};
        end
        if (i_cmd.pos_rd) begin
            r_pos_rd <= pos_mem[r_idx[PT_W-1:0]];
        end
        if (i_cmd.bin_wr) begin
            bin_mem[r_idx[PT_W-1:0]] <= r_cell;
        end
        if (i_cmd.bin_rd) begin
            r_bin_rd <= bin_mem[r_idx[PT_W-1:0]];
        end
        if (i_cmd.place_wr) begin
            sid_mem[end_dec[PT_W-1:0]] <= r_idx[PT_W-1:0];
        end
        if (i_cmd.q_step) begin
            r_sid_rd <= sid_mem[r_j[PT_W-1:0]];
        end
    end

    // cell counts
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr || i_cmd.walk_wr) begin
            cnt_mem[r_idx] <= '0;
        end else if (i_cmd.cnt_inc) begin
            cnt_mem[r_cell] <= r_cnt_rd + CNT_W'(1);
        end
        if (i_cmd.bin_wr) begin
            r_cnt_rd <= cnt_mem[r_cell];
        end else if (i_cmd.cnt_rd) begin
            r_cnt_rd <= cnt_mem[r_idx];
        end
    end

    // cell bounds, cells past the built grid read as the point count
    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_wr) begin
            end_mem[r_idx] <= run_n;
        end else if (i_cmd.place_wr) begin
            end_mem[r_bin_rd] <= end_dec;
        end
        if (i_cmd.end_rd_p || i_cmd.q_end_rd) begin
            r_end_ma <= end_mem[ra_a];
            r_a_hi   <= ({1'b0, ra_a} >= r_ncells);
        end
        if (i_cmd.q_end_rd) begin
            r_end_mb <= end_mem[ra_b[CELL_W-1:0]];
            r_b_hi   <= (ra_b >= r_ncells);
        end
    end

    // arithmetic and query datapath
    always_ff @(posedge i_clk) begin
        if (i_cmd.query) begin
            r_qx  <= i_pos_x;
            r_qy  <= i_pos_y;
            r_tag <= i_query_id;
        end
        if (i_cmd.mul_x || i_cmd.mul_y) begin
            r_prod <= prod_n;
        end
        if (i_cmd.mul_y) begin
            r_gx <= r_prod[PROD_W-1:FRAC_W];
        end
        if (i_cmd.cap_gy) begin
            r_gy <= r_prod[PROD_W-1:FRAC_W];
        end
        if (i_cmd.bin_cmul || i_cmd.q_cmul) begin
            r_cmul <= cmul_n[CELL_W-1:0];
        end
        if (i_cmd.bin_cell) begin
            r_cell <= r_cmul + CELL_W'(clamp_coord(r_gy, i_cfg.ny));
        end else if (i_cmd.q_cell) begin
            r_cell <= r_cmul + CELL_W'(r_y);
        end
        if (i_cmd.walk_init) begin
            r_run <= '0;
        end else if (i_cmd.walk_wr) begin
            r_run <= run_n;
        end
        if (i_cmd.q_lim) begin
            r_empty <= lim_ex || lim_ey;
            r_x1    <= hi_x;
            r_y0    <= lo_y;
            r_y1    <= hi_y;
            r_x     <= lo_x;
            r_y     <= lo_y;
        end else if (i_cmd.q_next) begin
            if (r_y < r_y1) begin
                r_y <= r_y + CO_W'(1);
            end else begin
                r_x <= r_x + CO_W'(1);
                r_y <= r_y0;
            end
        end
        if (i_cmd.q_bnd) begin
            r_j    <= end_a;
            r_jend <= end_b;
        end else if (i_cmd.q_step) begin
            r_j <= r_j + CNT_W'(1);
        end
        if (i_cmd.q_lim) begin
            r_count <= '0;
        end else if (i_cmd.q_id) begin
            r_count <= r_count + CNT_W'(1);
        end
        if (i_cmd.q_id) begin
            r_pend_id <= r_sid_rd;
        end
        o_tag_out     <= r_tag;
        o_neighbor_id <= (i_cmd.q_fin && !r_pend_v) ? '0 : r_pend_id;
        o_found       <= i_cmd.q_fin ? r_pend_v : 1'b1;
        o_last        <= i_cmd.q_fin;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total    <= '0;
            r_set_open <= 1'b0;
            r_idx      <= '0;
            r_ncells   <= '0;
            r_nb       <= '0;
            r_pend_v   <= 1'b0;
            o_valid    <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (!r_set_open) begin
                    r_total <= CNT_W'(1);
                end else if (wr_ok) begin
                    r_total <= r_total + CNT_W'(1);
                end
                r_set_open <= !i_last_point;
            end
            if (i_cmd.idx_zero) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + CELL_W'(1);
            end
            if (i_cmd.walk_init) begin
                r_ncells <= ncells_n[CELL_W:0];
                r_nb     <= r_total;
            end
            if (i_cmd.q_lim) begin
                r_pend_v <= 1'b0;
            end else if (i_cmd.q_id) begin
                r_pend_v <= 1'b1;
            end
            o_valid <= (i_cmd.q_id && r_pend_v) || i_cmd.q_fin;
        end
    end

    assign o_sts.pt_last   = (idx_p1 == (CELL_W+1)'(r_total));
    assign o_sts.cell_last = (idx_p1 == r_ncells);
    assign o_sts.clr_last  = (idx_p1 == (CELL_W+1)'(CELL_CAP));
    assign o_sts.q_empty   = r_empty;
    assign o_sts.j_more    = (r_j < r_jend) && (r_count < CNT_W'(MAX_POINTS));
    assign o_sts.y_more    = (r_y < r_y1);
    assign o_sts.x_more    = (r_x < r_x1);

endmodule
`default_nettype wire

// File: test/sgns_checker.sv
`default_nettype none
module sgns_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic                              i_opcode,
    input  logic [sgns_pkg::POS_W-1:0]        i_pos_x,
    input  logic [sgns_pkg::POS_W-1:0]        i_pos_y,
    input  logic                              i_last_point,
    input  logic [sgns_pkg::TAG_W-1:0]        i_query_id,
    input  logic                              o_valid,
    input  logic [sgns_pkg::TAG_W-1:0]        o_tag_out,
    input  logic [sgns_pkg::ID_W-1:0]         o_neighbor_id,
    input  logic                              o_found,
    input  logic                              o_last,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic                              pready,
    input  logic [sgns_pkg::ADDR_W-1:0]       paddr,
    input  logic [sgns_pkg::DATA_W-1:0]       pwdata,
    output int                                fail_count,
    output int                                pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import sgns_pkg::*;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [ID_W-1:0]  id;
        logic             found;
        logic             last;
    } t_hit;

    logic [DIM_W-1:0] nx_reg, ny_reg;
    logic [INV_W-1:0] inv_reg;
    logic [31:0]      pos_store [MAX_POINTS];
    int               total;
    bit               set_open;
    int               cell_ends [CELL_CAP+1];
    logic [ID_W-1:0]  sorted [MAX_POINTS];
    t_hit             hits_due [$];

    assign pending = hits_due.size();

    function automatic int grid_coord(logic [15:0] raw);
        longint p;
        p = longint'($signed(raw)) * longint'(inv_reg);
        return int'(p >>> 16);
    endfunction

    function automatic int eff(logic [DIM_W-1:0] n, int hi);
        if (n < 1) return 1;
        if (n > hi) return hi;
        return n;
    endfunction

    function automatic int clampi(int v, int hi);
        return v < 0 ? 0 : (v > hi ? hi : v);
    endfunction

    function automatic int bin_of(logic [31:0] packed_pos, int nx, int ny);
        return clampi(grid_coord(packed_pos[31:16]), nx - 1) * ny
             + clampi(grid_coord(packed_pos[15:0]), ny - 1);
    endfunction

    // counting sort of the stored set into the cell bounds
    task automatic build_grid();
        int nx, ny, run, c;
        int counts [CELL_CAP];
        nx = eff(nx_reg, MAX_CELLS_X);
        ny = eff(ny_reg, MAX_CELLS_Y);
        run = 0;
        for (int i = 0; i < CELL_CAP; i++) counts[i] = 0;
        for (int i = 0; i < total; i++) counts[bin_of(pos_store[i], nx, ny)]++;
        for (int i = 0; i <= CELL_CAP; i++) begin
            if (i < nx * ny) run += counts[i];
            cell_ends[i] = run;
        end
        for (int i = 0; i < total; i++) begin
            c = bin_of(pos_store[i], nx, ny);
            cell_ends[c]--;
            sorted[cell_ends[c] % MAX_POINTS] = i[ID_W-1:0];
        end
    endtask

    task automatic predict_query(logic [15:0] px, logic [15:0] py, logic [TAG_W-1:0] tag);
        int nx, ny, cx, cy, x0, x1, y0, y1, c, cnt;
        t_hit h;
        nx = eff(nx_reg, MAX_CELLS_X);
        ny = eff(ny_reg, MAX_CELLS_Y);
        cx = grid_coord(px);
        cy = grid_coord(py);
        x0 = cx - 1 < 0 ? 0 : cx - 1;
        y0 = cy - 1 < 0 ? 0 : cy - 1;
        x1 = cx + 1 > nx - 1 ? nx - 1 : cx + 1;
        y1 = cy + 1 > ny - 1 ? ny - 1 : cy + 1;
        cnt = 0;
        for (int x = x0; x <= x1; x++)
            for (int y = y0; y <= y1; y++) begin
                c = x * ny + y;
                for (int j = cell_ends[c]; j < cell_ends[c+1] && cnt < MAX_POINTS; j++) begin
                    h.tag = tag;
                    h.id = sorted[j % MAX_POINTS];
                    h.found = 1'b1;
                    h.last = 1'b0;
                    hits_due.push_back(h);
                    cnt++;
                end
            end
        if (cnt == 0) begin
            h.tag = tag;
            h.id = '0;
            h.found = 1'b0;
            h.last = 1'b1;
            hits_due.push_back(h);
        end else begin
            hits_due[hits_due.size()-1].last = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        t_hit got, want;
        if (!i_rst_n) begin
            nx_reg <= CELLS_X_RST;
            ny_reg <= CELLS_Y_RST;
            inv_reg <= INV_RST;
            total = 0;
            set_open = 0;
            for (int i = 0; i <= CELL_CAP; i++) cell_ends[i] = 0;
            for (int i = 0; i < MAX_POINTS; i++) sorted[i] = '0;
            hits_due.delete();
            fail_count = 0;
        end else begin
            // result side first: a result never belongs to a query taken at the same edge
            if (o_valid) begin
                got = '{o_tag_out, o_neighbor_id, o_found, o_last};
                if (hits_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result tag=%h id=%0d found=%b last=%b",
                                 got.tag, got.id, got.found, got.last);
                end else begin
                    want = hits_due.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("result mismatch: exp tag=%h id=%0d found=%b last=%b, got tag=%h id=%0d found=%b last=%b",
                                     want.tag, want.id, want.found, want.last,
                                     got.tag, got.id, got.found, got.last);
                    end
                end
            end
            if (start && !busy) begin
                if (i_opcode == OP_LOAD) begin
                    if (!set_open) begin
                        total = 0;
                        set_open = 1;
                    end
                    if (total < MAX_POINTS) begin
                        pos_store[total] = {i_pos_x, i_pos_y};
                        total++;
                    end
                    if (i_last_point) begin
                        build_grid();
                        set_open = 0;
                    end
                end else begin
                    predict_query(i_pos_x, i_pos_y, i_query_id);
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_CELLS_X: nx_reg <= pwdata[DIM_W-1:0];
                    REG_CELLS_Y: ny_reg <= pwdata[DIM_W-1:0];
                    REG_INV:     inv_reg <= pwdata[INV_W-1:0];
                    default: ;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

// File: test/spatial_grid_neighbor_search_tb.sv
`default_nettype none
module spatial_grid_neighbor_search_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sgns_pkg::*;

    localparam int STALL_LIMIT = 100000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic i_opcode = OP_LOAD;
    logic [POS_W-1:0] i_pos_x = '0;
    logic [POS_W-1:0] i_pos_y = '0;
    logic i_last_point = 1'b0;
    logic [TAG_W-1:0] i_query_id = '0;
    logic o_valid, o_found, o_last;
    logic [TAG_W-1:0] o_tag_out;
    logic [ID_W-1:0] o_neighbor_id;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;
    int fail_count, pending;
    int quiet_cycles = 0;
    int idle_pct = 0;
    int cur_nx = 16, cur_ny = 16, cur_inv = 256;
    int tag_seq = 0;

    // clock, 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    spatial_grid_neighbor_search DUT (
        .i_clk, .i_rst_n, .start, .busy, .i_opcode,
        .i_pos_x(signed'(i_pos_x)), .i_pos_y(signed'(i_pos_y)),
        .i_last_point, .i_query_id, .o_valid, .o_tag_out, .o_neighbor_id,
        .o_found, .o_last, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready
    );

    sgns_checker u_checker (
        .i_clk, .i_rst_n, .start, .busy, .i_opcode, .i_pos_x, .i_pos_y,
        .i_last_point, .i_query_id, .o_valid, .o_tag_out, .o_neighbor_id,
        .o_found, .o_last, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .fail_count, .pending
    );

    // watchdog: cycles in which no transaction, result or register write moves
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("spatial_grid_neighbor_search_tb NOT OK");
            $finish;
        end
    end

    // one input transaction; start stays high into the next call when there is no gap
    task automatic send(logic op, logic [15:0] x, logic [15:0] y, logic lp,
                        logic [15:0] tag);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_opcode <= op;
        i_pos_x <= x;
        i_pos_y <= y;
        i_last_point <= lp;
        i_query_id <= tag;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic query(logic [15:0] x, logic [15:0] y);
        tag_seq++;
        send(OP_QUERY, x, y, $urandom_range(1), tag_seq[15:0] ^ 16'($urandom));
    endtask

    // register write: setup cycle then access cycle
    task automatic reg_write(logic [1:0] idx, int val);
        start <= 1'b0;
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(idx) << 2;
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // all results in and the build, if any, finished
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_grid(int nx, int ny, int inv);
        drain();
        reg_write(REG_CELLS_X, nx);
        reg_write(REG_CELLS_Y, ny);
        reg_write(REG_INV, inv);
        cur_nx = nx < 1 ? 1 : (nx > MAX_CELLS_X ? MAX_CELLS_X : nx);
        cur_ny = ny < 1 ? 1 : (ny > MAX_CELLS_Y ? MAX_CELLS_Y : ny);
        cur_inv = inv;
    endtask

    // mostly a coordinate landing near the grid, sometimes any 16-bit value
    function automatic logic [15:0] coord_near(int n);
        longint p;
        if (cur_inv == 0 || $urandom_range(99) < 25) return 16'($urandom);
        p = ((longint'($urandom_range(n + 1)) - 1) * 65536 + $urandom_range(65535)) / cur_inv;
        if (p > 32767) p = 32767;
        if (p < -32768) p = -32768;
        return 16'(p);
    endfunction

    // a set of loads closed by last_point, queries sprinkled in while loading
    task automatic random_set(int npts);
        for (int i = 0; i < npts; i++) begin
            if ($urandom_range(99) < 8) query(coord_near(cur_nx), coord_near(cur_ny));
            send(OP_LOAD, coord_near(cur_nx), coord_near(cur_ny), i == npts - 1,
                 16'($urandom));
        end
    endtask

    task automatic random_phase(int items);
        int sent, k;
        sent = 0;
        while (sent < items) begin
            k = ($urandom_range(19) == 0) ? 66 : $urandom_range(1, 12);
            random_set(k);
            sent += k;
            repeat ($urandom_range(2, 8)) begin
                query(coord_near(cur_nx), coord_near(cur_ny));
                sent++;
            end
            // loose queries that may be anywhere
            if ($urandom_range(3) == 0) begin
                query(16'($urandom), 16'($urandom));
                sent++;
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part under reset settings: one cell per unit
        query(16'h0000, 16'h0000);                         // before any build
        send(OP_LOAD, 16'h0000, 16'h0000, 1'b0, 16'hFFFF);
        send(OP_LOAD, 16'h7FFF, 16'h7FFF, 1'b0, 16'h0000); // clamped high
        send(OP_LOAD, 16'h8000, 16'h8000, 1'b0, 16'h0000); // clamped low
        send(OP_LOAD, 16'h0100, 16'h0100, 1'b0, 16'h0000);
        send(OP_LOAD, 16'h0080, 16'h00FF, 1'b1, 16'h0000); // closes the set
        send(OP_QUERY, 16'h0000, 16'h0000, 1'b1, 16'h0000);
        send(OP_QUERY, 16'h0100, 16'h0100, 1'b0, 16'hFFFF);
        send(OP_QUERY, 16'h7FFF, 16'h7FFF, 1'b0, 16'hA5A5);
        send(OP_QUERY, 16'h8000, 16'h8000, 1'b1, 16'h5A5A); // far out
        send(OP_QUERY, 16'h0F00, 16'h0F00, 1'b0, 16'h1234);
        send(OP_LOAD, 16'h0300, 16'h0300, 1'b0, 16'h0000); // new set open
        send(OP_QUERY, 16'h0100, 16'h0100, 1'b0, 16'h0001); // still old grid
        send(OP_LOAD, 16'h0301, 16'h02FF, 1'b1, 16'h0000);
        send(OP_QUERY, 16'h0300, 16'h0300, 1'b0, 16'h0002);
        // grid size changed after the build, old bounds stay
        set_grid(4, 4, 256);
        query(16'h0100, 16'h0100);
        query(16'h0300, 16'h0300);

        // random part over several settings and idle rates
        idle_pct = 0;   set_grid(16, 16, 256);  random_phase(12);
        idle_pct = 48;  set_grid(1, 1, 65535);  random_phase(10);
        idle_pct = 6;   set_grid(64, 64, 1);    random_phase(8);
        idle_pct = 0;   set_grid(0, 127, 0);    random_phase(8);
        idle_pct = 48;  set_grid(8, 3, 512);    random_phase(12);
        idle_pct = 6;   set_grid(64, 2, 4096);  random_phase(10);
        idle_pct = 0;   set_grid(5, 64, 100);   random_phase(10);

        drain();
        if (fail_count == 0)
            $display("spatial_grid_neighbor_search_tb OK");
        else
            $display("spatial_grid_neighbor_search_tb NOT OK");
        $finish;
    end
endmodule
`default_nettype wire

// File: filelist.f
+incdir+rtl
rtl/sgns_pkg.sv
rtl/sgns_regs.sv
rtl/sgns_ctrl.sv
rtl/sgns_dp.sv
rtl/spatial_grid_neighbor_search.sv
test/sgns_checker.sv
test/spatial_grid_neighbor_search_tb.sv
